/* sv/dwc_pkg.sv */
// Shared constants and types for the depthwise 3x3 int8 convolution block.
// No dependencies; used by dwc_lane and the top level.
`default_nettype none
package dwc_pkg;
  localparam int CHANNELS  = 8;
  localparam int LANE_W    = 8;
  localparam int PIX_W     = 8 * LANE_W;
  localparam int MAX_WIDTH = 64;
  localparam int LS_AW     = $clog2(MAX_WIDTH);
  localparam int TAPS      = 9;
  localparam int ACC_W     = 20;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic [2:0] REG_MULT   = 3'd0;
  localparam logic [2:0] REG_SHIFT  = 3'd1;
  localparam logic [2:0] REG_ZP     = 3'd2;
  localparam logic [2:0] REG_WIDTH  = 3'd3;
  localparam logic [2:0] REG_HEIGHT = 3'd4;

  typedef struct packed {
    logic acc_en;
    logic mul_en;
    logic rq_en;
  } lane_ctrl_t;
endpackage
`default_nettype wire

/* sv/dwc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module dwc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* sv/dwc_lane.sv */
// One channel lane: nine-tap multiply-accumulate, 32-bit wrapping scale,
// rounding shift, zero-point offset and int8 saturation. Uses dwc_pkg.
`default_nettype none
module dwc_lane (
  input  wire logic                                   clk,
  input  wire dwc_pkg::lane_ctrl_t                    ctrl,
  input  wire logic [dwc_pkg::TAPS-1:0][7:0]          pix,
  input  wire logic [dwc_pkg::TAPS-1:0][7:0]          wt,
  input  wire logic [31:0]                            mult,
  input  wire logic [4:0]                             shift,
  input  wire logic [7:0]                             zp,
  output logic      [7:0]                             res
);
  logic signed [dwc_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic signed [15:0] tprod;
  logic [31:0] prod_r, prod_nxt;
  logic [7:0]  res_r, res_nxt;

  always_comb begin
    acc_nxt = '0;
    tprod   = '0;
    for (int k = 0; k < dwc_pkg::TAPS; k++) begin
      tprod   = $signed(pix[k]) * $signed(wt[k]);
      acc_nxt = acc_nxt + dwc_pkg::ACC_W'(tprod);
    end
  end

  assign prod_nxt = 32'(32'($signed(acc_r)) * mult);

  // Round half away from zero on the magnitude, then restore the sign.
  logic        neg;
  logic [32:0] mag, half, rsum, shd;
  logic [33:0] sres, zsum;
  always_comb begin
    neg  = prod_r[31];
    mag  = neg ? (33'd0 - {1'b1, prod_r}) : {1'b0, prod_r};
    half = (shift == 5'd0) ? 33'd0 : (33'd1 << (shift - 5'd1));
    rsum = mag + half;
    shd  = rsum >> shift;
    sres = neg ? (34'd0 - {1'b0, shd}) : {1'b0, shd};
    zsum = sres + 34'($signed(zp));
    if ($signed(zsum) > 34'sd127) begin
      res_nxt = 8'h7f;
    end else if ($signed(zsum) < -34'sd128) begin
      res_nxt = 8'h80;
    end else begin
      res_nxt = zsum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.acc_en) begin
      acc_r <= acc_nxt;
    end
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (ctrl.rq_en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;
endmodule
`default_nettype wire

/* sv/depthwise_conv3x3_int8_requant.sv */
// Top level of the depthwise 3x3 int8 convolution with requantization.
// Depends on dwc_pkg, dwc_ram and dwc_lane.
`default_nettype none
// The block takes one word at a time: a load word writes one weight tap for all
// eight channels and leaves the block idle for the next word, a pixel word
// (raster order) updates the two line buffers and the 3x3 window and then emits
// zero to four output words. After its accept cycle a pixel word goes through
// the line-buffer read and the window update, each output word it causes goes
// through the eight parallel channel lanes (select, accumulate, scale, round,
// output) plus however long the receiver stalls it, and a last select finds no
// output left. Input is stalled for the whole of that time. The line buffers
// hold rows y-1 and y-2 in two RAMs of MAX_WIDTH words; they are not cleared,
// and a frame's first row uses neither while its second row uses only row y-1.
// Configuration is over an APB-style port with pready always high and should
// be written only while the block is idle.
module depthwise_conv3x3_int8_requant (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_opcode,
  input  wire logic [3:0]  in_tap_index,
  input  wire logic [7:0]  in_lane0,
  input  wire logic [7:0]  in_lane1,
  input  wire logic [7:0]  in_lane2,
  input  wire logic [7:0]  in_lane3,
  input  wire logic [7:0]  in_lane4,
  input  wire logic [7:0]  in_lane5,
  input  wire logic [7:0]  in_lane6,
  input  wire logic [7:0]  in_lane7,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_result_row,
  output logic [5:0]       out_result_col,
  output logic [7:0]       out_ch0,
  output logic [7:0]       out_ch1,
  output logic [7:0]       out_ch2,
  output logic [7:0]       out_ch3,
  output logic [7:0]       out_ch4,
  output logic [7:0]       out_ch5,
  output logic [7:0]       out_ch6,
  output logic [7:0]       out_ch7,
  output logic             out_run_last,
  output logic             out_frame_done,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int PW = dwc_pkg::PIX_W;
  localparam int AW = dwc_pkg::LS_AW;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_RD   = 8'b0000_0010,
    ST_PX   = 8'b0000_0100,
    ST_SEL  = 8'b0000_1000,
    ST_MAC  = 8'b0001_0000,
    ST_MUL  = 8'b0010_0000,
    ST_RQ   = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [31:0] mult_r;
  logic [4:0]  shift_r;
  logic [7:0]  zp_r;
  logic [6:0]  width_r;
  logic [15:0] height_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r   <= 32'd1;
      shift_r  <= 5'd0;
      zp_r     <= 8'd0;
      width_r  <= 7'd14;
      height_r <= 16'd14;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        dwc_pkg::REG_MULT:   mult_r   <= pwdata;
        dwc_pkg::REG_SHIFT:  shift_r  <= pwdata[4:0];
        dwc_pkg::REG_ZP:     zp_r     <= pwdata[7:0];
        dwc_pkg::REG_WIDTH:  width_r  <= pwdata[6:0];
        dwc_pkg::REG_HEIGHT: height_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      dwc_pkg::REG_MULT:   prdata = mult_r;
      dwc_pkg::REG_SHIFT:  prdata = {27'd0, shift_r};
      dwc_pkg::REG_ZP:     prdata = {24'd0, zp_r};
      dwc_pkg::REG_WIDTH:  prdata = {25'd0, width_r};
      dwc_pkg::REG_HEIGHT: prdata = {16'd0, height_r};
      default:             prdata = 32'd0;
    endcase
  end

  // Input acceptance and the weight taps.
  logic          in_acc;
  logic [PW-1:0] in_word;
  logic [dwc_pkg::TAPS-1:0][PW-1:0] wt_r;
  logic [PW-1:0] px_r;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign in_word  = {in_lane7, in_lane6, in_lane5, in_lane4,
                     in_lane3, in_lane2, in_lane1, in_lane0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wt_r <= '0;
    end else if (in_acc && in_opcode == dwc_pkg::OP_LOAD &&
                 in_tap_index < 4'(dwc_pkg::TAPS)) begin
      wt_r[in_tap_index] <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r <= in_word;
    end
  end

  // Line buffers: lo holds row y-1, hi holds row y-2.
  logic [AW-1:0] col_r, col_nxt;
  logic [15:0]   row_r, row_nxt;
  logic [PW-1:0] lo_rdata, hi_rdata, topw, midw;
  logic          ls_we;

  assign ls_we = (state_r == ST_PX);
  assign topw  = (row_r >= 16'd2) ? hi_rdata : '0;
  assign midw  = (row_r >= 16'd1) ? lo_rdata : '0;

  dwc_ram #(.WIDTH(PW), .DEPTH(dwc_pkg::MAX_WIDTH)) u_ls_lo (
    .clk(clk), .we(ls_we), .waddr(col_r), .wdata(px_r),
    .raddr(col_r), .rdata(lo_rdata)
  );
  dwc_ram #(.WIDTH(PW), .DEPTH(dwc_pkg::MAX_WIDTH)) u_ls_hi (
    .clk(clk), .we(ls_we), .waddr(col_r), .wdata(midw),
    .raddr(col_r), .rdata(hi_rdata)
  );

  // Effective geometry and row/column bookkeeping for a pixel.
  logic [6:0]  weff;
  logic [15:0] heff;
  logic        rowend, lastrow;

  always_comb begin
    if (width_r == 7'd0) begin
      weff = 7'd1;
    end else if (width_r > 7'(dwc_pkg::MAX_WIDTH)) begin
      weff = 7'(dwc_pkg::MAX_WIDTH);
    end else begin
      weff = width_r;
    end
    heff    = (height_r == 16'd0) ? 16'd1 : height_r;
    rowend  = (7'(col_r) + 7'd1) >= weff;
    lastrow = (17'(row_r) + 17'd1) >= 17'(heff);
    if (rowend) begin
      col_nxt = '0;
      row_nxt = lastrow ? 16'd0 : row_r + 16'd1;
    end else begin
      col_nxt = col_r + AW'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (state_r == ST_PX) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // 3x3 window, indexed [column][row]; column 2 is the newest.
  logic [2:0][2:0][PW-1:0] win_r, win_nxt, win_base;

  always_comb begin
    win_base = (col_r == '0) ? '0 : win_r;
    win_nxt[0] = win_base[1];
    win_nxt[1] = win_base[2];
    win_nxt[2][0] = topw;
    win_nxt[2][1] = midw;
    win_nxt[2][2] = px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (state_r == ST_PX) begin
      win_r <= win_nxt;
    end
  end

  // Pending outputs of the current pixel, one bit each in emission order:
  // interior of the row above, right edge of the row above, then the same
  // two for the last row of the frame.
  logic [3:0]    emask_r, emask_nxt;
  logic [15:0]   prow_r;
  logic [AW-1:0] pcol_r, wlast_r;

  always_comb begin
    emask_nxt[0] = (row_r >= 16'd1) && (col_r != '0);
    emask_nxt[1] = (row_r >= 16'd1) && rowend;
    emask_nxt[2] = lastrow && (col_r != '0);
    emask_nxt[3] = lastrow && rowend;
  end

  // Selection of the next output and its shifted window.
  logic [1:0]    pick;
  logic [3:0]    rest;
  logic [dwc_pkg::TAPS-1:0][PW-1:0] ewin_r, ewin_nxt;
  logic [15:0]   erow_r;
  logic [AW-1:0] ecol_r;
  logic          elast_r, edone_r;

  always_comb begin
    if (emask_r[0]) begin
      pick = 2'd0;
    end else if (emask_r[1]) begin
      pick = 2'd1;
    end else if (emask_r[2]) begin
      pick = 2'd2;
    end else begin
      pick = 2'd3;
    end
    rest = emask_r & ~(4'b0001 << pick);
    for (int ky = 0; ky < 3; ky++) begin
      for (int kx = 0; kx < 3; kx++) begin
        if (kx + int'(pick[0]) < 3 && ky + int'(pick[1]) < 3) begin
          ewin_nxt[ky*3+kx] = win_r[kx + int'(pick[0])][ky + int'(pick[1])];
        end else begin
          ewin_nxt[ky*3+kx] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_PX) begin
      prow_r  <= row_r;
      pcol_r  <= col_r;
      wlast_r <= AW'(weff - 7'd1);
    end
    if (state_r == ST_SEL) begin
      ewin_r  <= ewin_nxt;
      erow_r  <= pick[1] ? prow_r : prow_r - 16'd1;
      ecol_r  <= pick[0] ? wlast_r : pcol_r - AW'(1);
      elast_r <= (rest == 4'd0);
      edone_r <= (pick == 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emask_r <= '0;
    end else if (state_r == ST_PX) begin
      emask_r <= emask_nxt;
    end else if (state_r == ST_SEL) begin
      emask_r <= rest;
    end
  end

  // Channel lanes.
  dwc_pkg::lane_ctrl_t lctrl;
  logic [7:0][7:0] lane_res;

  assign lctrl.acc_en = (state_r == ST_MAC);
  assign lctrl.mul_en = (state_r == ST_MUL);
  assign lctrl.rq_en  = (state_r == ST_RQ);

  for (genvar c = 0; c < 8; c++) begin : g_lane
    if (c < dwc_pkg::CHANNELS) begin : g_on
      logic [dwc_pkg::TAPS-1:0][7:0] lpix, lwt;
      for (genvar k = 0; k < dwc_pkg::TAPS; k++) begin : g_tap
        assign lpix[k] = ewin_r[k][8*c +: 8];
        assign lwt[k]  = wt_r[k][8*c +: 8];
      end
      dwc_lane u_lane (
        .clk(clk), .ctrl(lctrl), .pix(lpix), .wt(lwt),
        .mult(mult_r), .shift(shift_r), .zp(zp_r), .res(lane_res[c])
      );
    end else begin : g_off
      assign lane_res[c] = 8'd0;
    end
  end

  // Sequencer.
  logic out_valid_r, out_acc;
  assign out_acc = out_valid_r && !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc && in_opcode == dwc_pkg::OP_PIXEL) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_PX;
      ST_PX:   state_nxt = ST_SEL;
      ST_SEL:  state_nxt = (emask_r == 4'd0) ? ST_IDLE : ST_MAC;
      ST_MAC:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_RQ;
      ST_RQ:   state_nxt = ST_OUT;
      ST_OUT:  if (out_acc) state_nxt = ST_SEL;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Merge stage: the lanes' registered results and the position become one
  // output word. The lane results are written at the end of ST_RQ and hold
  // until the next ST_RQ, so they stay steady while the word waits.
  logic [15:0]     orow_r;
  logic [AW-1:0]   ocol_r;
  logic            olast_r, odone_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_RQ) begin
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RQ) begin
      orow_r  <= erow_r;
      ocol_r  <= ecol_r;
      olast_r <= elast_r;
      odone_r <= edone_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_result_row = orow_r;
  assign out_result_col = 6'(ocol_r);
  assign out_ch0        = lane_res[0];
  assign out_ch1        = lane_res[1];
  assign out_ch2        = lane_res[2];
  assign out_ch3        = lane_res[3];
  assign out_ch4        = lane_res[4];
  assign out_ch5        = lane_res[5];
  assign out_ch6        = lane_res[6];
  assign out_ch7        = lane_res[7];
  assign out_run_last   = olast_r;
  assign out_frame_done = odone_r;

  a_valid_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_OUT))
    else $error("output word held outside the output state");
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_done) |-> out_run_last)
    else $error("frame end is not the last word of its pixel");
  a_pixel_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_opcode == dwc_pkg::OP_PIXEL) |=> (state_r == ST_RD))
    else $error("pixel word did not start a line-buffer read");
  a_mask_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEL && emask_r != 4'd0) |=>
      ($countones(emask_r) + 1 == $countones($past(emask_r))))
    else $error("pending output mask did not drop one entry");
endmodule
`default_nettype wire
